FILE: rtl/sgm_pkg.sv
`default_nettype none

package sgm_pkg;

    // field and datapath widths
    localparam int PixW      = 8;
    localparam int MagW      = 11;
    localparam int WidthRegW = 11;
    localparam int HeightRegW = 12;
    localparam int CfgDataW  = 12;
    localparam int CfgIdxW   = 1;
    // counters and clamped sizes, wide enough for a row count of 4096
    localparam int CntW      = 13;
    // one weighted 1,2,1 sum of three pixels
    localparam int SumW      = 10;
    // signed gradient, -1020 to 1020
    localparam int GradW     = 11;
    // square of one gradient, below 2^20
    localparam int SqHalfW   = 20;
    // sum of both squares
    localparam int SqW       = 21;
    // one root bit per step
    localparam int SqrtSteps = 11;

    localparam int DefMaxWidth = 1024;
    localparam int MinDim      = 3;

    localparam logic [WidthRegW-1:0]  ResetWidth  = WidthRegW'(640);
    localparam logic [HeightRegW-1:0] ResetHeight = HeightRegW'(480);

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SOBEL,
        ST_SQUARE,
        ST_ROOT
    } state_t;

    // border masks for the window of the current result
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } mask_t;

    // control from the sequencer to the window datapath
    typedef struct packed {
        logic  shift_en;
        logic  calc_en;
        mask_t mask;
    } win_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sgm_ram.sv
`default_nettype none

module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/sgm_sobel.sv
`default_nettype none

module sgm_sobel import sgm_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire win_ctrl_t           ctrl,
    input  wire logic [PixW-1:0]     col_top,
    input  wire logic [PixW-1:0]     col_mid,
    input  wire logic [PixW-1:0]     col_bot,
    output logic      [SqW-1:0]      sum_sq
);

    // window, [row: top,mid,bottom][col: left,mid,right]
    logic [PixW-1:0] win_reg [3][3];
    logic [PixW-1:0] p [3][3];

    logic [SumW-1:0] top_sum;
    logic [SumW-1:0] bot_sum;
    logic [SumW-1:0] left_sum;
    logic [SumW-1:0] right_sum;

    logic signed [GradW-1:0] gx_next;
    logic signed [GradW-1:0] gy_next;
    logic signed [GradW-1:0] gx_reg;
    logic signed [GradW-1:0] gy_reg;

    logic signed [2*GradW-1:0] gx_sq;
    logic signed [2*GradW-1:0] gy_sq;

    // shift left and bring in the new column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (ctrl.shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= col_top;
            win_reg[1][2] <= col_mid;
            win_reg[2][2] <= col_bot;
        end
    end

    // zero padding at the image borders
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p[i][j] = win_reg[i][j];
            end
        end
        if (ctrl.mask.right)
        begin
            for (int i = 0; i < 3; i++) p[i][2] = '0;
        end
        if (ctrl.mask.left)
        begin
            for (int i = 0; i < 3; i++) p[i][0] = '0;
        end
        if (ctrl.mask.top)
        begin
            for (int j = 0; j < 3; j++) p[0][j] = '0;
        end
        if (ctrl.mask.bottom)
        begin
            for (int j = 0; j < 3; j++) p[2][j] = '0;
        end
    end

    // weighted 1,2,1 sums along the four window edges
    assign top_sum   = SumW'(p[0][0]) + (SumW'(p[0][1]) << 1) + SumW'(p[0][2]);
    assign bot_sum   = SumW'(p[2][0]) + (SumW'(p[2][1]) << 1) + SumW'(p[2][2]);
    assign left_sum  = SumW'(p[0][0]) + (SumW'(p[1][0]) << 1) + SumW'(p[2][0]);
    assign right_sum = SumW'(p[0][2]) + (SumW'(p[1][2]) << 1) + SumW'(p[2][2]);

    assign gx_next = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
    assign gy_next = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});

    // gradient register
    always_ff @(posedge clk)
    begin
        if (ctrl.calc_en)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    // squares and their sum, registered by the root unit
    assign gx_sq  = gx_reg * gx_reg;
    assign gy_sq  = gy_reg * gy_reg;
    assign sum_sq = {1'b0, gx_sq[SqHalfW-1:0]} + {1'b0, gy_sq[SqHalfW-1:0]};

endmodule

`default_nettype wire

FILE: rtl/sgm_sqrt.sv
`default_nettype none

module sgm_sqrt import sgm_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [SqW-1:0]  operand,
    output logic                 done,
    output logic      [MagW-1:0] root
);

    localparam logic [SqW-1:0] FirstBit = SqW'(1) << (2 * (SqrtSteps - 1));

    logic [SqW-1:0] rem_reg;
    logic [SqW-1:0] rem_next;
    logic [SqW-1:0] res_reg;
    logic [SqW-1:0] res_next;
    logic [SqW-1:0] bit_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [SqW:0]   trial;

    // one restoring step: try res + bit against the remainder
    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        if ({1'b0, rem_reg} >= trial)
        begin
            rem_next = rem_reg - trial[SqW-1:0];
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    // remainder, partial root and bit position
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= operand;
            res_reg <= '0;
            bit_reg <= FirstBit;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[MagW-1:0];

endmodule

`default_nettype wire

FILE: rtl/sobel_gradient_magnitude.sv
`default_nettype none

// Streaming 3x3 Sobel gradient magnitude. Grey pixels come in raster order on
// the input channel (cmd 0); each result is floor(sqrt(gx^2 + gy^2)) for the
// pixel W+1 transfers back, with zero padding at all image borders. A frame is
// W*H pixel transfers followed by W+1 flush transfers (cmd 1), and the result
// of the last flush transfer carries last_of_frame. Width and height are
// clamped to [3, MAX_WIDTH] and to at least 3; write them only while the
// block is idle. Both line stores share one MAX_WIDTH x 16 memory, read and
// written back once per pixel. After reset a clearing pass zeroes that
// memory before the first pixel is taken. A pixel is taken only when idle;
// it passes the read state and, for a result, the Sobel, square and root
// states, the root state paced by the 11-step bit-serial square root unit.
// The output register lets the next pixel be taken while a result waits.
module sobel_gradient_magnitude import sgm_pkg::*; #(
    parameter int MAX_WIDTH = DefMaxWidth
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [PixW-1:0]     pixel,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [MagW-1:0]     magnitude,
    output logic                     last_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CntW-1:0] MaxW     = CntW'(MAX_WIDTH);
    localparam logic [CntW-1:0] MinD     = CntW'(MinDim);
    localparam logic [AW-1:0]   LastAddr = AW'(MAX_WIDTH - 1);

    // configuration
    logic [WidthRegW-1:0]  width_reg;
    logic [HeightRegW-1:0] height_reg;
    logic [CntW-1:0]       w_eff;
    logic [CntW-1:0]       h_eff;

    // sequencer
    state_t state_reg;
    state_t state_next;
    logic [AW-1:0] clr_cnt_reg;

    // raster counters and per-pixel control
    logic [AW-1:0]   col_reg;
    logic [AW-1:0]   col_next;
    logic [CntW-1:0] row_reg;
    logic [CntW-1:0] row_next;
    logic [CntW-1:0] col_inc;
    logic [CntW-1:0] crow;
    logic [AW-1:0]   idx_reg;
    logic [PixW-1:0] px_reg;
    logic [PixW-1:0] px_next;
    logic            emit_reg;
    logic            emit_next;
    logic            last_reg;
    logic            last_next;
    mask_t           mask_reg;
    mask_t           mask_next;
    logic            in_xfer;

    // memory port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [2*PixW-1:0]   ram_wdata;
    logic [2*PixW-1:0]   ram_rdata;

    // datapath control
    win_ctrl_t     win_ctrl;
    logic [SqW-1:0] sum_sq;
    logic          sqrt_start;
    logic          sqrt_done;
    logic [MagW-1:0] root;
    logic          load_out;

    // output register
    logic            out_valid_reg;
    logic [MagW-1:0] magnitude_reg;
    logic            last_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ResetWidth;
            height_reg <= ResetHeight;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WidthRegW-1:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // clamped image size
    always_comb
    begin
        w_eff = CntW'(width_reg);
        if (w_eff < MinD)
        begin
            w_eff = MinD;
        end
        else if (w_eff > MaxW)
        begin
            w_eff = MaxW;
        end
        h_eff = CntW'(height_reg);
        if (h_eff < MinD)
        begin
            h_eff = MinD;
        end
    end

    assign in_xfer = in_valid && in_ready;

    // per-pixel decisions from the current raster position
    always_comb
    begin
        col_inc   = CntW'(col_reg) + CntW'(1);
        last_next = (row_reg >= h_eff + CntW'(1));
        emit_next = last_next || (row_reg >= CntW'(2))
                    || ((row_reg == CntW'(1)) && (col_reg != '0));
        px_next   = (!cmd && (row_reg < h_eff)) ? pixel : '0;
        crow      = (col_reg == '0) ? row_reg - CntW'(2) : row_reg - CntW'(1);

        mask_next.right  = (col_reg == '0);
        mask_next.left   = (col_reg == AW'(1));
        mask_next.top    = (crow == '0);
        mask_next.bottom = (crow == h_eff - CntW'(1));

        if (last_next)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + CntW'(1);
        end
        else
        begin
            col_next = col_inc[AW-1:0];
            row_next = row_reg;
        end
    end

    // raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            emit_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            emit_reg <= emit_next;
        end
    end

    // per-pixel payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            idx_reg  <= col_reg;
            px_reg   <= px_next;
            last_reg <= last_next;
            mask_reg <= mask_next;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LastAddr) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid) state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = emit_reg ? ST_SOBEL : ST_IDLE;
            end
            ST_SOBEL:
            begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (load_out) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready           = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = idx_reg;
        ram_wdata          = {ram_rdata[PixW-1:0], px_reg};
        win_ctrl.shift_en  = 1'b0;
        win_ctrl.calc_en   = 1'b0;
        win_ctrl.mask      = mask_reg;
        sqrt_start         = 1'b0;
        load_out           = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                // upper line takes the middle, middle takes the new pixel
                ram_we            = 1'b1;
                win_ctrl.shift_en = 1'b1;
            end
            ST_SOBEL:
            begin
                win_ctrl.calc_en = 1'b1;
            end
            ST_SQUARE:
            begin
                sqrt_start = 1'b1;
            end
            ST_ROOT:
            begin
                load_out = sqrt_done && (!out_valid_reg || out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // both line stores, upper in the high byte
    sgm_ram #(
        .WIDTH (2 * PixW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    sgm_sobel u_sobel (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .col_top (ram_rdata[2*PixW-1:PixW]),
        .col_mid (ram_rdata[PixW-1:0]),
        .col_bot (px_reg),
        .sum_sq  (sum_sq)
    );

    sgm_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sum_sq),
        .done    (sqrt_done),
        .root    (root)
    );

    // output register, freed by a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            magnitude_reg <= root;
            last_out_reg  <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign magnitude     = magnitude_reg;
    assign last_of_frame = last_out_reg;

endmodule

`default_nettype wire

FILE: bench/tb_sobel_gradient_magnitude.sv
`timescale 1ns / 100ps

module tb_sobel_gradient_magnitude;
    import sgm_pkg::*;

    // one pixel-channel transfer
    typedef struct packed {
        logic            flush;
        logic [PixW-1:0] grey;
    } beat_t;

    // one predicted result
    typedef struct packed {
        logic [MagW-1:0] mag;
        logic            frame_end;
    } gradient_t;

    // how the grey levels of a frame are drawn
    typedef enum int {
        GREY_RANDOM,
        GREY_BINARY,
        GREY_RAMP,
        GREY_NEAR_EXTREMES
    } grey_style_t;

    // output stall behavior
    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_CHOKED
    } sink_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    cfg_idx_t            cfg_index = CFG_WIDTH;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                cmd = 1'b0;
    logic [PixW-1:0]     pixel = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [MagW-1:0]     magnitude;
    logic                last_of_frame;

    sobel_gradient_magnitude uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .magnitude     (magnitude),
        .last_of_frame (last_of_frame)
    );

    // pixel beats waiting for the driver, results waiting for the output
    beat_t     pixel_beats[$];
    gradient_t pending_gradients[$];

    // predictor copy of the registers and the window state
    logic [WidthRegW-1:0]  width_reg;
    logic [HeightRegW-1:0] height_reg;
    logic [PixW-1:0]       line_top [DefMaxWidth];
    logic [PixW-1:0]       line_mid [DefMaxWidth];
    logic [PixW-1:0]       win [3][3];
    int unsigned           row_cnt;
    int unsigned           col_cnt;

    // raster position of the stimulus generator
    int unsigned gen_row;
    int unsigned gen_col;

    int queued_count = 0;
    int acc_count = 0;
    int results_checked = 0;
    int frames_seen = 0;
    int mismatch_count = 0;

    // driver burst state
    int burst_left;
    int gap_left;

    // receiver stall state
    sink_mode_t  sink_mode;
    int          mode_left;
    logic [15:0] sink_pat;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned cols_in_use(input int unsigned reg_val);
        if (reg_val < MinDim)
            return MinDim;
        if (reg_val > DefMaxWidth)
            return DefMaxWidth;
        return reg_val;
    endfunction

    function automatic int unsigned rows_in_use(input int unsigned reg_val);
        return (reg_val < MinDim) ? MinDim : reg_val;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // advance the window by one transfer and queue the result it gives, if any
    function automatic void predict_gradient(input logic is_flush, input logic [PixW-1:0] grey);
        int unsigned     w, h, r, c, idx, crow, sq, root, trial;
        logic [PixW-1:0] px;
        int              p [3][3];
        int              gx, gy, i, j, b;
        bit              at_end, emit;
        gradient_t       res;
        w = cols_in_use(width_reg);
        h = rows_in_use(height_reg);
        r = row_cnt;
        c = col_cnt;
        px = (!is_flush && r < h) ? grey : '0;
        idx = (c < DefMaxWidth) ? c : 0;

        // shift left, new column from the line stores and the incoming pixel
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_top[idx];
        win[1][2] = line_mid[idx];
        win[2][2] = px;
        line_top[idx] = line_mid[idx];
        line_mid[idx] = px;

        at_end = (r >= h + 1);
        emit = at_end || r >= 2 || (r == 1 && c >= 1);

        // raster counters
        if (at_end)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        else if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
        end
        else
            col_cnt = c + 1;

        if (!emit)
            return;

        // zero padding at the borders of the pixel being finished
        crow = (c == 0) ? r - 2 : r - 1;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                p[i][j] = win[i][j];
        for (i = 0; i < 3; i++)
        begin
            if (c == 0)
                p[i][2] = 0;
            if (c == 1)
                p[i][0] = 0;
            if (crow == 0)
                p[0][i] = 0;
            if (crow == h - 1)
                p[2][i] = 0;
        end
        gx = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        gy = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        sq = gx * gx + gy * gy;

        // floor square root, one bit at a time from the top
        root = 0;
        for (b = 11; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        res.mag = root[MagW-1:0];
        res.frame_end = at_end;
        pending_gradients.push_back(res);
    endfunction

    task automatic push_beat(input logic is_flush, input logic [PixW-1:0] grey);
        beat_t bt;
        bt.flush = is_flush;
        bt.grey = grey;
        pixel_beats.push_back(bt);
        queued_count++;
    endtask

    // queue raster beats from the generator position, to the frame end or a limit
    task automatic queue_beats(input int unsigned w, input int unsigned h, input int limit,
                               input grey_style_t style, input int flush_pct,
                               input int drain_pct);
        int              n;
        bit              at_end;
        logic [PixW-1:0] grey;
        n = 0;
        at_end = 0;
        while (!at_end && (limit < 0 || n < limit))
        begin
            at_end = (gen_row >= h + 1);
            if (gen_row < h)
            begin
                case (style)
                    GREY_BINARY: grey = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    GREY_RAMP: grey = PixW'(gen_row * 29 + gen_col * 53);
                    GREY_NEAR_EXTREMES:
                        grey = $urandom_range(0, 1) ? PixW'($urandom_range(0, 15))
                                                    : PixW'($urandom_range(240, 255));
                    default: grey = PixW'($urandom);
                endcase
                push_beat($urandom_range(0, 99) < flush_pct, grey);
            end
            else
                push_beat(!($urandom_range(0, 99) < drain_pct), PixW'($urandom));
            n++;
            if (at_end)
            begin
                gen_row = 0;
                gen_col = 0;
            end
            else if (gen_col + 1 >= w)
            begin
                gen_col = 0;
                gen_row++;
            end
            else
                gen_col++;
        end
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // every transfer taken and every result back, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (acc_count != queued_count || pending_gradients.size() != 0);
        repeat (24) @(negedge clk);
    endtask

    // pixel driver: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= 1'b0;
            pixel <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_beats.size() != 0)
            begin
                nxt = pixel_beats.pop_front();
                in_valid <= 1'b1;
                cmd <= nxt.flush;
                pixel <= nxt.grey;
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        burst_left <= 300;
                        gap_left <= 0;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= $urandom_range(0, 10);
                    end
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: a random stall mode, redrawn when its run ends
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_mode <= SINK_OPEN;
            mode_left <= 0;
            sink_pat <= 16'h0001;
        end
        else if (mode_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(200, 1200);
            sink_pat <= 16'($urandom) | 16'h0001;
            out_ready <= 1'b1;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (sink_mode)
                SINK_OPEN: out_ready <= 1'b1;
                SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                SINK_PATTERN:
                begin
                    out_ready <= sink_pat[0];
                    sink_pat <= {sink_pat[0], sink_pat[15:1]};
                end
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: register writes, result checks and prediction per accepted transfer
    always @(posedge clk)
    begin
        gradient_t want;
        if (!rst_n)
        begin
            width_reg = ResetWidth;
            height_reg = ResetHeight;
            for (int k = 0; k < DefMaxWidth; k++)
            begin
                line_top[k] = '0;
                line_mid[k] = '0;
            end
            for (int k = 0; k < 9; k++)
                win[k / 3][k % 3] = '0;
            row_cnt = 0;
            col_cnt = 0;
            pending_gradients.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH: width_reg = cfg_data[WidthRegW-1:0];
                    CFG_HEIGHT: height_reg = cfg_data[HeightRegW-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending_gradients.size() == 0)
                    report_mismatch("result transfer with nothing expected", magnitude, -1);
                else
                begin
                    want = pending_gradients.pop_front();
                    if (magnitude !== want.mag)
                        report_mismatch("magnitude", magnitude, want.mag);
                    if (last_of_frame !== want.frame_end)
                        report_mismatch("last_of_frame", last_of_frame, want.frame_end);
                end
                results_checked++;
                if (last_of_frame === 1'b1)
                    frames_seen++;
            end
            if (in_valid && in_ready)
            begin
                predict_gradient(cmd, pixel);
                acc_count++;
            end
        end
    end

    // stimulus and run control
    initial
    begin
        int unsigned wr_width, wr_height, w_eff, h_eff, new_w, new_h;
        int          pick, which, limit, before_cnt, rand_items, phases, spin;
        grey_style_t style;
        int          flush_pct, drain_pct;

        rand_items = 0;
        phases = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame from out-of-range sizes, flush inside the image and a
        // pixel transfer during the drain
        cfg_write(CFG_WIDTH, 12'd0);
        cfg_write(CFG_HEIGHT, 12'd1);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'h00);
        push_beat(1'b1, 8'hA5);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b1, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b1, 8'hFF);
        push_beat(1'b1, 8'h00);
        wait_idle();
        phases++;

        // widest rows and tallest frame, filled past two full rows
        cfg_write(CFG_WIDTH, 12'hFFF);
        cfg_write(CFG_HEIGHT, 12'hFFF);
        wr_width = 12'hFFF & 12'h7FF;
        wr_height = 12'hFFF;
        gen_row = row_cnt;
        gen_col = col_cnt;
        before_cnt = queued_count;
        queue_beats(cols_in_use(wr_width), rows_in_use(wr_height), 2 * DefMaxWidth + 6,
                    GREY_RANDOM, 0, 0);
        rand_items += queued_count - before_cnt;
        wait_idle();
        phases++;

        // random phases; a partial phase leaves the next one to start mid-frame
        while (rand_items < 2000)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                new_w = $urandom_range(3, 12);
            else if (pick == 6)
                new_w = $urandom_range(0, 2);
            else if (pick <= 8)
                new_w = $urandom_range(13, 64);
            else
                new_w = $urandom_range(1025, 4095);
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                new_h = $urandom_range(3, 8);
            else if (pick == 6)
                new_h = $urandom_range(0, 2);
            else if (pick <= 8)
                new_h = $urandom_range(9, 40);
            else
                new_h = $urandom_range(41, 4095);

            which = $urandom_range(0, 4);
            if (which != 1)
            begin
                cfg_write(CFG_WIDTH, CfgDataW'(new_w));
                wr_width = new_w & 32'h7FF;
            end
            if (which != 0)
            begin
                cfg_write(CFG_HEIGHT, CfgDataW'(new_h));
                wr_height = new_h & 32'hFFF;
            end

            w_eff = cols_in_use(wr_width);
            h_eff = rows_in_use(wr_height);
            gen_row = row_cnt;
            gen_col = col_cnt;
            style = grey_style_t'($urandom_range(0, 3));
            flush_pct = ($urandom_range(0, 3) == 0) ? 5 : 0;
            drain_pct = ($urandom_range(0, 1) == 0) ? 30 : 0;
            before_cnt = queued_count;

            if (w_eff * h_eff > 600)
                queue_beats(w_eff, h_eff, $urandom_range(10, 300), style, flush_pct, drain_pct);
            else if ($urandom_range(0, 7) == 0)
            begin
                limit = $urandom_range(1, w_eff * h_eff);
                queue_beats(w_eff, h_eff, limit, style, flush_pct, drain_pct);
            end
            else
                repeat ($urandom_range(1, 3))
                    queue_beats(w_eff, h_eff, -1, style, flush_pct, drain_pct);

            rand_items += queued_count - before_cnt;
            wait_idle();
            phases++;
        end

        // drain and settle
        do
            @(negedge clk);
        while (acc_count != queued_count);
        for (spin = 0; spin < 20000 && pending_gradients.size() != 0; spin++)
            @(negedge clk);
        if (pending_gradients.size() != 0)
            report_mismatch("results never delivered", 0, pending_gradients.size());
        repeat (40) @(negedge clk);

        $display("Covered %0d pixel transfers and %0d checked results in %0d phases",
                 acc_count, results_checked, phases);
        $display("%0d frame ends seen, rows from 3 to %0d columns wide", frames_seen,
                 DefMaxWidth);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
